[rtl/core/wdwr_pkg.sv]
// ----------------------------------------------------------------------------
// wdwr_pkg
// Shared types and constants for the weighted draw without replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package wdwr_pkg;

  localparam int unsigned ENTRIES_DEF    = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned TOTAL_BITS  = 22;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned LEFT_W      = 16;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned RANDOM_W    = 31;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_DRAW   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_TOTAL_ZERO = 2'd1,
    STS_FULL       = 2'd2,
    STS_NOT_FOUND  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [WEIGHT_W-1:0] weight;
    logic [RANDOM_W-1:0] random;
  } wdwr_req_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_W-1:0]     picked_slot;
    logic [LEFT_W-1:0]     picked_left;
    logic [TOTAL_BITS-1:0] total_left;
  } wdwr_rsp_t;

endpackage

`default_nettype wire

[rtl/core/wdwr_ram.sv]
// ----------------------------------------------------------------------------
// wdwr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wdwr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/wdwr_mod.sv]
// ----------------------------------------------------------------------------
// wdwr_mod
// Bit-serial restoring remainder unit: random value modulo the running total,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wdwr_mod
  import wdwr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [RANDOM_W-1:0]   dividend_i,
  input  wire logic [TOTAL_BITS-1:0] divisor_i,
  output logic                       done_o,
  output logic [TOTAL_BITS-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(RANDOM_W);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RANDOM_W-1:0]   dvd_q, dvd_d;
  logic [TOTAL_BITS:0]   rem_q, rem_d;
  logic [TOTAL_BITS-1:0] div_q, div_d;
  logic [TOTAL_BITS:0]   rem_sh;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    rem_sh = {rem_q[TOTAL_BITS-1:0], dvd_q[RANDOM_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      dvd_d = {dvd_q[RANDOM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sh - {1'b0, div_q};
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(RANDOM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[TOTAL_BITS-1:0];

endmodule

`default_nettype wire

[rtl/core/weighted_draw_without_replacement_top.sv]
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement_top
// Table of reference counts with a running total; appends entries and draws
// one entry at random in proportion to its remaining count.
// ----------------------------------------------------------------------------
// append, or draw with a zero total: result strobe in the cycle after the request
// draw: serial remainder unit first, then one slot per cycle over
//   the table (RAM read pipelined)
// busy is high while a draw is in progress; the receiver cannot stall results
// reset clears the slot count and the total; table RAM needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_draw_without_replacement_top
  import wdwr_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire wdwr_req_t req_i,
  output logic           busy,
  output logic           done_o,
  output wdwr_rsp_t      rsp_o
);

  localparam int unsigned ADDR_W = $clog2(ENTRIES);
  localparam int unsigned USED_W = $clog2(ENTRIES + 1);
  localparam int unsigned SUM_W  =
    ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;
  localparam int unsigned CMP_W  = (COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_WALK = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [USED_W-1:0]     used_q, used_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic [USED_W-1:0]     rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0]     chk_idx_q, chk_idx_d;
  logic                  dvld_q, dvld_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [TOTAL_BITS-1:0] target_q, target_d;
  logic                  done_q, done_d;
  wdwr_rsp_t             rsp_q, rsp_d;

  logic                  mod_start;
  logic                  mod_done;
  logic [TOTAL_BITS-1:0] mod_rem;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] rdata;

  logic [COUNT_BITS-1:0] w_cnt;
  logic [SUM_W-1:0]      tot_add;
  logic [TOTAL_BITS-1:0] tot_sat;
  logic [SUM_W-1:0]      sum_nx;
  logic                  hit;
  logic [COUNT_BITS-1:0] dec_cnt;

  assign w_cnt   = (CMP_W'(req_i.weight) > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                 : COUNT_BITS'(CMP_W'(req_i.weight));
  assign tot_add = SUM_W'(total_q) + SUM_W'(w_cnt);
  assign tot_sat = (tot_add > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(tot_add);
  assign sum_nx  = sum_q + SUM_W'(rdata);
  assign hit     = SUM_W'(target_q) < sum_nx;
  assign dec_cnt = rdata - 1'b1;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    total_d   = total_q;
    rd_idx_d  = rd_idx_q;
    chk_idx_d = chk_idx_q;
    dvld_d    = dvld_q;
    sum_d     = sum_q;
    target_d  = target_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mod_start = 1'b0;
    we        = 1'b0;
    waddr     = used_q[ADDR_W-1:0];
    wdata     = w_cnt;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          done_d = 1'b1;
          if (req_i.cmd == CMD_APPEND) begin
            if (used_q >= USED_W'(ENTRIES)) begin
              rsp_d = '{status: STS_FULL, picked_slot: '0, picked_left: '0,
                        total_left: total_q};
            end else begin
              we      = 1'b1;
              used_d  = used_q + 1'b1;
              total_d = tot_sat;
              rsp_d   = '{status: STS_OK, picked_slot: SLOT_W'(used_q),
                          picked_left: LEFT_W'(w_cnt), total_left: tot_sat};
            end
          end else if (total_q == '0) begin
            rsp_d = '{status: STS_TOTAL_ZERO, picked_slot: '0, picked_left: '0,
                      total_left: '0};
          end else begin
            done_d    = 1'b0;
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          target_d = mod_rem;
          rd_idx_d = '0;
          dvld_d   = 1'b0;
          sum_d    = '0;
          state_d  = ST_WALK;
        end
      end

      ST_WALK: begin
        if (rd_idx_q < used_q) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_idx_d = rd_idx_q[ADDR_W-1:0];
          dvld_d    = 1'b1;
        end else begin
          dvld_d = 1'b0;
        end
        if (dvld_q && hit) begin
          we      = 1'b1;
          waddr   = chk_idx_q;
          wdata   = dec_cnt;
          total_d = total_q - 1'b1;
          done_d  = 1'b1;
          rsp_d   = '{status: STS_OK, picked_slot: SLOT_W'(chk_idx_q),
                      picked_left: LEFT_W'(dec_cnt), total_left: total_q - 1'b1};
          state_d = ST_IDLE;
        end else begin
          if (dvld_q) begin
            sum_d = sum_nx;
          end
          if (rd_idx_q >= used_q) begin
            done_d  = 1'b1;
            rsp_d   = '{status: STS_NOT_FOUND, picked_slot: '0, picked_left: '0,
                        total_left: total_q};
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      dvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      total_q <= total_d;
      done_q  <= done_d;
      dvld_q  <= dvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    sum_q     <= sum_d;
    target_q  <= target_d;
    rsp_q     <= rsp_d;
  end

  wdwr_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(req_i.random),
    .divisor_i (total_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  wdwr_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

[tb/wdwr_checker.sv]
// ----------------------------------------------------------------------------
// wdwr_checker
// Watches the request and result channels of the weighted draw block, keeps
// its own copy of the slot table and the running total, predicts each result
// at request time and compares every strobed result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module wdwr_checker
  import wdwr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      busy_i,
  input  wire wdwr_req_t req_i,
  input  wire logic      done_i,
  input  wire wdwr_rsp_t rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEFT_W-1:0]     slot_count [ENTRIES_DEF];
  int unsigned           used_slots;
  logic [TOTAL_BITS-1:0] running_total;
  wdwr_rsp_t             draw_result_q [$];
  int                    errors;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    wdwr_rsp_t   want;
    logic [63:0] target;
    logic [63:0] sum;
    bit          found;
    if (!rst_ni) begin
      used_slots    = 0;
      running_total = '0;
      errors        = 0;
      draw_result_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_i) begin
        if (draw_result_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, actual %h", $time, rsp_i);
        end else begin
          want = draw_result_q.pop_front();
          if (rsp_i.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_i.status);
          end
          if (rsp_i.picked_slot !== want.picked_slot) begin
            errors++;
            $display("%0t: picked_slot mismatch, expected %0d, actual %0d",
                     $time, want.picked_slot, rsp_i.picked_slot);
          end
          if (rsp_i.picked_left !== want.picked_left) begin
            errors++;
            $display("%0t: picked_left mismatch, expected %0d, actual %0d",
                     $time, want.picked_left, rsp_i.picked_left);
          end
          if (rsp_i.total_left !== want.total_left) begin
            errors++;
            $display("%0t: total_left mismatch, expected %0d, actual %0d",
                     $time, want.total_left, rsp_i.total_left);
          end
        end
      end

      if (start_i && !busy_i) begin
        want = '0;
        if (req_i.cmd == CMD_APPEND) begin
          if (used_slots >= ENTRIES_DEF) begin
            want.status     = STS_FULL;
            want.total_left = running_total;
          end else begin
            slot_count[used_slots] = req_i.weight;
            sum = 64'(running_total) + 64'(req_i.weight);
            running_total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
            want.status      = STS_OK;
            want.picked_slot = used_slots[SLOT_W-1:0];
            want.picked_left = req_i.weight;
            want.total_left  = running_total;
            used_slots++;
          end
        end else if (running_total == '0) begin
          want.status = STS_TOTAL_ZERO;
        end else begin
          target = 64'(req_i.random) % 64'(running_total);
          sum    = '0;
          found  = 1'b0;
          want.status     = STS_NOT_FOUND;
          want.total_left = running_total;
          for (int i = 0; i < int'(used_slots) && !found; i++) begin
            sum += 64'(slot_count[i]);
            if (target < sum) begin
              found         = 1'b1;
              slot_count[i] = slot_count[i] - 1'b1;
              running_total = running_total - 1'b1;
              want.status      = STS_OK;
              want.picked_slot = i[SLOT_W-1:0];
              want.picked_left = slot_count[i];
              want.total_left  = running_total;
            end
          end
        end
        draw_result_q.push_back(want);
      end

      fail_count_o <= errors;
      pending_o    <= draw_result_q.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_weighted_draw_without_replacement_top.sv]
// ----------------------------------------------------------------------------
// tb_weighted_draw_without_replacement_top
// Drives append and draw requests into the weighted draw block: a directed
// opening over empty-table, zero-weight and drained-slot cases, then random
// requests in three phases of sender idling. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_weighted_draw_without_replacement_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wdwr_pkg::*;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  wdwr_req_t req_i  = '0;
  logic      busy;
  logic      done_o;
  wdwr_rsp_t rsp_o;
  int        fail_count;
  int        pending;
  int        idle_pct;
  int        appends_sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weighted_draw_without_replacement_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  wdwr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic wdwr_req_t make_req(cmd_e cmd, logic [WEIGHT_W-1:0] weight,
                                         logic [RANDOM_W-1:0] rnd);
    wdwr_req_t r;
    r.cmd    = cmd;
    r.weight = weight;
    r.random = rnd;
    return r;
  endfunction

  task automatic send_request(input wdwr_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    if (r.cmd == CMD_APPEND) appends_sent++;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic wdwr_req_t random_req();
    cmd_e                cmd;
    logic [WEIGHT_W-1:0] weight;
    int                  pick;
    cmd  = ($urandom_range(99) < 35) ? CMD_APPEND : CMD_DRAW;
    pick = $urandom_range(99);
    // small weights while the table fills so that slots and the total drain
    if (appends_sent < 48) weight = WEIGHT_W'($urandom_range(0, 3));
    else if (pick < 10) weight = ($urandom_range(1) != 0) ? '1 : '0;
    else if (pick < 55) weight = WEIGHT_W'($urandom_range(0, 65535));
    else weight = WEIGHT_W'($urandom_range(0, 15));
    return make_req(cmd, weight, RANDOM_W'($urandom()));
  endfunction

  initial begin
    idle_pct     = 27;
    appends_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, zero weight, drained slot
    send_request(make_req(CMD_DRAW,   16'd0, 31'd0));
    send_request(make_req(CMD_DRAW,   16'd0, 31'h7FFF_FFFF));
    send_request(make_req(CMD_APPEND, 16'd0, 31'h7FFF_FFFF));
    send_request(make_req(CMD_DRAW,   16'hFFFF, 31'h7FFF_FFFF));
    send_request(make_req(CMD_APPEND, 16'd1, 31'd0));
    send_request(make_req(CMD_DRAW,   16'd0, 31'h7FFF_FFFF));
    send_request(make_req(CMD_DRAW,   16'd0, 31'd0));
    send_request(make_req(CMD_APPEND, 16'd3, 31'h2AAA_AAAA));
    send_request(make_req(CMD_APPEND, 16'd2, 31'h5555_5555));
    send_request(make_req(CMD_DRAW,   16'd0, 31'd0));
    send_request(make_req(CMD_DRAW,   16'd0, 31'h7FFF_FFFF));
    send_request(make_req(CMD_DRAW,   16'hAAAA, 31'h2AAA_AAAA));
    send_request(make_req(CMD_DRAW,   16'h5555, 31'h5555_5555));
    send_request(make_req(CMD_DRAW,   16'd0, 31'd4));
    send_request(make_req(CMD_DRAW,   16'd0, 31'd1));
    send_request(make_req(CMD_DRAW,   16'd0, 31'd2));

    for (int n = 0; n < 950; n++) begin
      if (n == 317) begin
        // hold off until the block has answered everything
        wait_drained();
        idle_pct = 73;
      end
      if (n == 634) idle_pct = 0;
      send_request(random_req());
    end

    wait_drained();
    repeat (RANDOM_W + ENTRIES_DEF + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/wdwr_pkg.sv
rtl/core/wdwr_ram.sv
rtl/core/wdwr_mod.sv
rtl/core/weighted_draw_without_replacement_top.sv
tb/wdwr_checker.sv
tb/tb_weighted_draw_without_replacement_top.sv
